/* hdl/dmhq_pkg.sv */
// Shared types, constants and helpers for the d-ary max-heap queue.
package dmhq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int MAX_ARITY = 8;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;
  localparam int RCP_W     = 18;   // reciprocal scale, exact for indexes below CAPACITY

  typedef struct packed {
    logic [15:0]        tag;
    logic signed [31:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_POP    = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_APPEND = 3'd3,
    REQ_BUILD  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_START, S_UP_RD, S_UP_CMP, S_POP_TOP, S_POP_LAST,
    S_SCAN, S_UPD_DEC, S_BLD_INIT, S_BLD_NEXT, S_BLD_RD,
    S_SD_START, S_SD_CMP, S_SD_DEC, S_RESP
  } state_t;

  // ceil(2^RCP_W / d); x*recip >> RCP_W equals x/d for x below CAPACITY
  function automatic logic [RCP_W-1:0] recip(input logic [3:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      4'd3:    r = 18'd87382;
      4'd4:    r = 18'd65536;
      4'd5:    r = 18'd52429;
      4'd6:    r = 18'd43691;
      4'd7:    r = 18'd37450;
      4'd8:    r = 18'd32768;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

/* hdl/dary_max_heap_queue.sv */
// Top level: d-ary max-heap priority queue with a sequenced sift engine.
//
// Usage:
//  - Request channel (in_valid/in_ready): req_type, item_value, item_priority.
//    One transaction per request: insert, pop top, update priority, append,
//    build heap. Codes 5..7 do nothing and answer ok.
//  - Result channel (out_valid/out_ready): out_value, status, entry_count.
//    Exactly one result transaction per request.
//  - cfg_we/cfg_wdata write the arity (clamped to 2..8 when used).
// Timing: one request at a time; in_ready is high only when idle. Every
// step goes through one memory read port with registered data, so the
// time taken scales with the work:
//  - append / trivial cases: result in the cycle after accept
//  - sift up: per level climbed, S_UP_START, S_UP_RD (parent read), S_UP_CMP
//  - sift down: per level descended, S_SD_START, S_SD_CMP for each child, S_SD_DEC
//  - update: a linear tag search over all entries, then a sift
//  - build heap: a sift down per internal node
// The result register holds while out_ready is low; no new request is taken
// until the result transaction completes.
// Reset clears the entry count and sets arity to 2; the entry store itself
// is not cleared (only entries below the count are ever used).
module dary_max_heap_queue
  import dmhq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               req_type,
  input  logic [15:0]              item_value,
  input  logic signed [31:0]       item_priority,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_value,
  output logic [1:0]               status,
  output logic [10:0]              entry_count,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_wdata
);

  state_t state, state_next;

  entry_t mem [CAPACITY];
  entry_t rdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;
  entry_t           wdata;

  logic [3:0]       arity;
  logic [3:0]       d;
  logic [CNT_W-1:0] count;
  entry_t           cur;       // entry being sifted
  entry_t           best;      // largest child so far
  logic [IDX_W-1:0] best_idx;
  logic [IDX_W-1:0] pos;       // hole position
  logic [IDX_W-1:0] par;
  logic [IDX_W-1:0] c;         // child / scan index
  logic [IDX_W-1:0] last;
  logic             sd_init;
  logic             build;
  logic             found;
  logic signed [31:0] old_prio;
  logic [IDX_W-1:0] bi;
  logic [15:0]      outv;
  status_t          stat;

  // shared divide-by-arity unit (reciprocal multiply)
  logic [IDX_W-1:0]       div_x;
  logic [IDX_W+RCP_W-1:0] prod;
  logic [IDX_W-1:0]       quot;

  logic [13:0] first;
  logic [13:0] last_raw;
  logic        accept;

  assign d        = (arity < 4'd2) ? 4'd2 : (arity > 4'(MAX_ARITY)) ? 4'(MAX_ARITY) : arity;
  assign div_x    = (state == S_BLD_INIT) ? IDX_W'(count - CNT_W'(2)) : pos - IDX_W'(1);
  assign prod     = div_x * recip(d);
  assign quot     = prod[IDX_W+RCP_W-1:RCP_W];
  assign first    = 14'(d) * 14'(pos) + 14'd1;
  assign last_raw = first + 14'(d) - 14'd1;
  assign accept   = in_valid && in_ready;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_RESP);
  assign out_value   = outv;
  assign status      = stat;
  assign entry_count = count;

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_INSERT: state_next = (count == CNT_W'(CAPACITY)) ? S_RESP : S_UP_START;
            REQ_POP:    state_next = (count == '0) ? S_RESP : S_POP_TOP;
            REQ_UPDATE: state_next = (count == '0) ? S_RESP : S_SCAN;
            REQ_BUILD:  state_next = (count > CNT_W'(1)) ? S_BLD_INIT : S_RESP;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_UP_START: state_next = (pos == '0) ? S_RESP : S_UP_RD;
      S_UP_RD:    state_next = S_UP_CMP;
      S_UP_CMP:   state_next = (rdata.prio < cur.prio) ? S_UP_START : S_RESP;
      S_POP_TOP:  state_next = (count == CNT_W'(1)) ? S_RESP : S_POP_LAST;
      S_POP_LAST: state_next = S_SD_START;
      S_SCAN:     state_next = (CNT_W'(c) == count - CNT_W'(1)) ? S_UPD_DEC : S_SCAN;
      S_UPD_DEC: begin
        if (!found)                 state_next = S_RESP;
        else if (cur.prio > old_prio) state_next = S_UP_START;
        else if (cur.prio < old_prio) state_next = S_SD_START;
        else                        state_next = S_RESP;
      end
      S_BLD_INIT: state_next = S_BLD_NEXT;
      S_BLD_NEXT: state_next = (bi == '0) ? S_RESP : S_BLD_RD;
      S_BLD_RD:   state_next = S_SD_START;
      S_SD_START: begin
        if (first >= 14'(count)) state_next = build ? S_BLD_NEXT : S_RESP;
        else                     state_next = S_SD_CMP;
      end
      S_SD_CMP:   state_next = (c == last) ? S_SD_DEC : S_SD_CMP;
      S_SD_DEC: begin
        if (best.prio > cur.prio) state_next = S_SD_START;
        else                      state_next = build ? S_BLD_NEXT : S_RESP;
      end
      S_RESP:     state_next = out_ready ? S_IDLE : S_RESP;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    unique case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_INSERT || req_type == REQ_APPEND) &&
            count != CNT_W'(CAPACITY)) begin
          we    = 1'b1;
          waddr = count[IDX_W-1:0];
          wdata = '{tag: item_value, prio: item_priority};
        end
      end
      S_UP_START: we = (pos == '0);
      S_UP_RD:    raddr = par;
      S_UP_CMP: begin
        we = 1'b1;
        if (rdata.prio < cur.prio) wdata = rdata;
      end
      S_POP_TOP:  raddr = IDX_W'(count - CNT_W'(1));
      S_SCAN:     raddr = c + IDX_W'(1);
      S_BLD_NEXT: raddr = bi - IDX_W'(1);
      S_SD_START: begin
        raddr = first[IDX_W-1:0];
        we    = (first >= 14'(count));
      end
      S_SD_CMP:   raddr = c + IDX_W'(1);
      S_SD_DEC: begin
        we = 1'b1;
        if (best.prio > cur.prio) wdata = best;
      end
      default: ;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      arity <= 4'd2;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) arity <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur   <= '{tag: item_value, prio: item_priority};
            outv  <= '0;
            build <= 1'b0;
            found <= 1'b0;
            c     <= '0;
            pos   <= count[IDX_W-1:0];
            case (req_type)
              REQ_INSERT, REQ_APPEND: begin
                if (count == CNT_W'(CAPACITY)) begin
                  stat <= ST_FULL;
                end else begin
                  stat  <= ST_OK;
                  count <= count + CNT_W'(1);
                end
              end
              REQ_POP:    stat <= (count == '0) ? ST_EMPTY : ST_OK;
              REQ_UPDATE: stat <= (count == '0) ? ST_NOT_FOUND : ST_OK;
              default:    stat <= ST_OK;
            endcase
          end
        end
        S_UP_START: par <= quot;
        S_UP_CMP:   if (rdata.prio < cur.prio) pos <= par;
        S_POP_TOP: begin
          outv  <= rdata.tag;
          count <= count - CNT_W'(1);
        end
        S_POP_LAST: begin
          cur <= rdata;
          pos <= '0;
        end
        S_SCAN: begin
          if (rdata.tag == cur.tag) begin
            found    <= 1'b1;
            pos      <= c;
            old_prio <= rdata.prio;
          end
          c <= c + IDX_W'(1);
        end
        S_UPD_DEC:  if (!found) stat <= ST_NOT_FOUND;
        S_BLD_INIT: begin
          bi    <= quot + IDX_W'(1);
          build <= 1'b1;
        end
        S_BLD_NEXT: begin
          bi  <= bi - IDX_W'(1);
          pos <= bi - IDX_W'(1);
        end
        S_BLD_RD:   cur <= rdata;
        S_SD_START: begin
          c       <= first[IDX_W-1:0];
          sd_init <= 1'b1;
          last    <= (last_raw > 14'(count - CNT_W'(1))) ? IDX_W'(count - CNT_W'(1))
                                                         : last_raw[IDX_W-1:0];
        end
        S_SD_CMP: begin
          sd_init <= 1'b0;
          if (sd_init || rdata.prio > best.prio) begin
            best     <= rdata;
            best_idx <= c;
          end
          c <= c + IDX_W'(1);
        end
        S_SD_DEC:   if (best.prio > cur.prio) pos <= best_idx;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/dmhq_checker.sv */
// Port-level checker for the heap queue, bound to the top level.
module dmhq_checker
  import dmhq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_value,
  input logic [1:0]  status,
  input logic [10:0] entry_count
);

  // one request in flight: never ready while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // an accepted transaction closes the input side
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(entry_count))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0 && out_value == '0)
    else $error("empty pop with entries");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == 11'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind dary_max_heap_queue dmhq_checker u_dmhq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
  .status(status), .entry_count(entry_count)
);

/* dv/heap_result_checker.sv */
// Result checker for the d-ary max-heap queue: mirrors the heap and compares every result.
`timescale 1ns / 100ps
module heap_result_checker
  import dmhq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [15:0]        item_value,
  input  logic signed [31:0] item_priority,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        out_value,
  input  logic [1:0]         status,
  input  logic [10:0]        entry_count,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output int                 pending,
  output int                 errors
);

  typedef struct {
    logic [15:0] value;
    status_t     st;
    logic [10:0] count;
  } heap_result_t;

  heap_result_t expected_results[$];

  logic [15:0] tags[CAPACITY];
  int          prios[CAPACITY];
  int          held;
  logic [3:0]  arity_reg;

  function automatic int fanout();
    if (arity_reg < 2) return 2;
    if (arity_reg > MAX_ARITY) return MAX_ARITY;
    return arity_reg;
  endfunction

  task automatic climb(input int pos);
    int d, par, cp;
    logic [15:0] ct;
    d  = fanout();
    ct = tags[pos];
    cp = prios[pos];
    while (pos > 0) begin
      par = (pos - 1) / d;
      if (prios[par] < cp) begin
        tags[pos]  = tags[par];
        prios[pos] = prios[par];
        pos = par;
      end else break;
    end
    tags[pos]  = ct;
    prios[pos] = cp;
  endtask

  task automatic sink(input int pos);
    int d, first, last, best, cp;
    logic [15:0] ct;
    d  = fanout();
    ct = tags[pos];
    cp = prios[pos];
    forever begin
      first = d * pos + 1;
      if (first >= held) break;
      last = first + d - 1;
      if (last > held - 1) last = held - 1;
      best = first;
      for (int c = first + 1; c <= last; c++)
        if (prios[c] > prios[best]) best = c;
      if (prios[best] > cp) begin
        tags[pos]  = tags[best];
        prios[pos] = prios[best];
        pos = best;
      end else break;
    end
    tags[pos]  = ct;
    prios[pos] = cp;
  endtask

  task automatic predict_request(input logic [2:0] rq, input logic [15:0] tg,
                                 input int pr);
    heap_result_t r;
    int pos, old;
    bit hit;
    r.value = '0;
    r.st    = ST_OK;
    case (rq)
      REQ_INSERT, REQ_APPEND: begin
        if (held >= CAPACITY) r.st = ST_FULL;
        else begin
          tags[held]  = tg;
          prios[held] = pr;
          held++;
          if (rq == REQ_INSERT) climb(held - 1);
        end
      end
      REQ_POP: begin
        if (held == 0) r.st = ST_EMPTY;
        else begin
          r.value = tags[0];
          held--;
          if (held > 0) begin
            tags[0]  = tags[held];
            prios[0] = prios[held];
            sink(0);
          end
        end
      end
      REQ_UPDATE: begin
        hit = 0;
        pos = 0;
        for (int i = 0; i < held; i++)
          if (tags[i] == tg) begin
            pos = i;
            hit = 1;
          end
        if (!hit) r.st = ST_NOT_FOUND;
        else begin
          old = prios[pos];
          prios[pos] = pr;
          if (pr > old) climb(pos);
          else if (pr < old) sink(pos);
        end
      end
      REQ_BUILD: begin
        if (held > 1)
          for (int i = (held - 2) / fanout(); i >= 0; i--) sink(i);
      end
      default: ;
    endcase
    r.count = held[10:0];
    expected_results = {expected_results, r};
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    heap_result_t e;
    if (rst) begin
      held      = 0;
      arity_reg = 4'd2;
      expected_results.delete();
    end else begin
      if (cfg_we) arity_reg = cfg_wdata;
      if (in_valid && in_ready) predict_request(req_type, item_value, item_priority);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t result transaction with nothing outstanding", $realtime);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_value !== e.value) report("out_value", out_value, e.value);
          if (status !== e.st) report("status", status, e.st);
          if (entry_count !== e.count) report("entry_count", entry_count, e.count);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* dv/dary_max_heap_queue_test.sv */
// Testbench top for the d-ary max-heap queue: stimulus, result-side stalls and verdict.
`timescale 1ns / 100ps
module dary_max_heap_queue_test;
  import dmhq_pkg::*;

  // Watchdog: cycles with no transaction on either channel. A full-size
  // build heap or update search ends far below this limit.
  localparam int HANG_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         req_type = '0;
  logic [15:0]        item_value = '0;
  logic signed [31:0] item_priority = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_value;
  logic [1:0]         status;
  logic [10:0]        entry_count;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_wdata = '0;

  int pending;
  int errors;
  int idle_cycles;
  int stall_left;
  bit quiet;    // when set, neither side inserts idle cycles

  always #5 clk = ~clk;

  dary_max_heap_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .item_value(item_value), .item_priority(item_priority),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .status(status), .entry_count(entry_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  heap_result_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .item_value(item_value), .item_priority(item_priority),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .status(status), .entry_count(entry_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pending(pending), .errors(errors)
  );

  // Result side: after each result transaction, draw a random stall (none when quiet).
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_left <= quiet ? 0 : $urandom_range(0, 14);
      out_ready  <= quiet;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("dary_max_heap_queue verification failed");
      $finish;
    end
  end

  // One request transaction. The task waits on the clock before raising valid
  // again, so valid is never dropped and raised in the same step.
  task automatic send(input logic [2:0] rq, input logic [15:0] tg,
                      input logic signed [31:0] pr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    repeat (gap + 1) @(posedge clk);
    in_valid      <= 1'b1;
    req_type      <= rq;
    item_value    <= tg;
    item_priority <= pr;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  // Wait until every result is back; wait on the clock first so the last
  // accepted request is already counted as outstanding.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Arity is only written with the block idle: every result back first.
  task automatic set_arity(input logic [3:0] a);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Tags mostly from a small pool so updates find their target; priorities
  // mix a narrow band (lots of ties) with the full signed range.
  task automatic random_request();
    logic [2:0]  rq;
    logic [15:0] tg;
    logic [31:0] pr;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      rq = REQ_INSERT;
    else if (pick < 62) rq = REQ_POP;
    else if (pick < 80) rq = REQ_UPDATE;
    else if (pick < 90) rq = REQ_APPEND;
    else if (pick < 96) rq = REQ_BUILD;
    else                rq = 3'($urandom_range(5, 7));
    tg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
    pr = ($urandom_range(0, 1) == 0) ? $urandom : 32'($signed($urandom_range(0, 15)) - 8);
    send(rq, tg, pr);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      random_request();
    end
    quiet = 0;
  endtask

  initial begin
    quiet = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extremes, ties, each request kind.
    send(REQ_POP, 16'h1234, 0);                    // pop on empty
    send(REQ_UPDATE, 16'h0001, 5);                 // update with nothing held
    send(REQ_BUILD, 0, 0);                         // build on empty
    send(REQ_INSERT, 16'hFFFF, 32'sh8000_0000);
    send(REQ_BUILD, 0, 0);                         // build on one entry
    send(REQ_POP, 0, 0);                           // pop of the only entry
    send(REQ_INSERT, 16'h0000, 32'sh7FFF_FFFF);
    send(REQ_INSERT, 16'h0005, 32'sh8000_0000);
    send(REQ_INSERT, 16'h0006, 0);
    send(REQ_INSERT, 16'h0007, 0);                 // ties tag 0006's priority, climbs above 0005
    send(REQ_APPEND, 16'h0008, 32'sh7FFF_FFFF);    // out of order on purpose
    send(REQ_APPEND, 16'h0005, 3);                 // duplicate tag, higher index
    send(REQ_UPDATE, 16'h0005, 100);               // raise the last match
    send(REQ_UPDATE, 16'h0006, -50);               // lower
    send(REQ_UPDATE, 16'h0007, 0);                 // unchanged priority
    send(REQ_UPDATE, 16'hAAAA, 1);                 // tag not present
    send(REQ_BUILD, 0, 0);
    send(3'd5, 16'hFFFF, -1);
    send(3'd6, 0, 0);
    send(3'd7, 16'h5555, 32'sh5555_5555);
    repeat (7) send(REQ_POP, 0, 0);                // drain past empty

    random_phase(20);

    // Full store: append past capacity, then the deep operations.
    set_arity(4'd2);
    quiet = 1;
    repeat (CAPACITY + 4) send(REQ_APPEND, 16'($urandom_range(0, 4095)), $urandom);
    quiet = 0;
    send(REQ_INSERT, 16'h0BAD, 1);
    send(REQ_BUILD, 0, 0);
    send(REQ_UPDATE, 16'h0010, 32'sh8000_0000);
    send(REQ_UPDATE, 16'h0011, 32'sh7FFF_FFFF);

    // Several arities, out-of-range ones included, on a deep heap.
    set_arity(4'd0);     // below range, acts as binary
    random_phase(10);
    set_arity(4'd15);    // above range, acts as 8
    random_phase(10);
    set_arity(4'd3);
    random_phase(10);
    set_arity(4'd8);
    random_phase(10);
    set_arity(4'd5);
    random_phase(10);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("dary_max_heap_queue verification clean");
    else $display("dary_max_heap_queue verification failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/dmhq_pkg.sv
hdl/dary_max_heap_queue.sv
hdl/dmhq_checker.sv
dv/heap_result_checker.sv
dv/dary_max_heap_queue_test.sv
